/* hw/rtl/ctt_pkg.sv */
// connection tuple table: shared codes, state encoding and the control bundles
// between controller and datapath
// no dependencies
package ctt_pkg;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } ctt_mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DUP  = 2'd2,
    STAT_MISS = 2'd3
  } ctt_status_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_REMOVE,
    ST_COMMIT
  } ctt_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the input beat, reset scan trackers
    logic issue;    // read the entry at the scan address, advance it
    logic rd_slot;  // read the entry named by the remove slot
    logic commit;   // apply the operation and load the result register
  } ctt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    ctt_mode_e mode;      // mode of the captured beat
    logic      last_addr; // scan address is at the last entry
    logic      out_free;  // result register can take a new result
  } ctt_sts_t;

endpackage

/* hw/rtl/ctt_ram.sv */
// connection tuple table: generic single write port, single read port ram
// with registered read data; no dependencies
module ctt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ctt_ctrl.sv */
// connection tuple table: operation sequencer
// depends on ctt_pkg
module ctt_ctrl
  import ctt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctt_sts_t sts_i,
  output ctt_cmd_t cmd_o
);

  ctt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.mode)
          MODE_INSERT: state_d = ST_SCAN;
          MODE_FIND:   state_d = ST_SCAN;
          MODE_REMOVE: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = ST_REMOVE;
          end
          MODE_CLEAR:  state_d = ST_COMMIT;
          default:     state_d = ST_COMMIT;
        endcase
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_addr) begin
          state_d = ST_DRAIN;
        end
      end
      // last compare lands here
      ST_DRAIN: state_d = ST_COMMIT;
      // remove read data lands here
      ST_REMOVE: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/ctt_datapath.sv */
// connection tuple table: key/id storage, scan compare trackers, valid bits,
// counters and the result register; depends on ctt_pkg and ctt_ram
module ctt_datapath
  import ctt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctt_cmd_t    cmd_i,
  output ctt_sts_t    sts_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [5:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  entry_slot_o,
  output logic [31:0] conn_id_o,
  output logic        client_side_o,
  output logic [6:0]  entry_count_o
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int SX_W   = (IDX_W > 6) ? IDX_W : 6;
  localparam int CX_W   = (CNT_W > 7) ? CNT_W : 7;
  localparam int KEY_W  = 96;
  localparam int WORD_W = KEY_W + 32;

  // captured beat
  ctt_mode_e   mode_q;
  logic [31:0] saddr_q, daddr_q;
  logic [15:0] sport_q, dport_q;
  logic [5:0]  slot_q;

  // table state
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]       live_q, live_d;
  logic [31:0]            next_id_q, next_id_d;

  // scan pipeline
  logic [IDX_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  // scan trackers: forward key, swapped key, lowest free slot
  logic             hit_a_q, hit_b_q, free_q;
  logic [IDX_W-1:0] idx_a_q, idx_b_q, free_idx_q;
  logic [31:0]      id_a_q, id_b_q;

  // ram signals
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]  key_fwd, key_swp, rd_key;
  logic [31:0]       rd_id;

  // slot decode
  logic [SX_W-1:0]  slot_x;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;

  // result
  logic             out_valid_q;
  ctt_status_e      res_status;
  logic [5:0]       res_slot;
  logic [31:0]      res_id;
  logic             res_client;
  logic             ins_ok;
  logic             side;
  logic [SX_W-1:0]  pick_x;
  logic [IDX_W-1:0] pick_idx;
  logic [CX_W-1:0]  cnt_x;
  logic [1:0]       status_q;
  logic [5:0]       slot_out_q;
  logic [31:0]      id_out_q;
  logic             client_q;
  logic [6:0]       count_q;

  assign key_fwd = {saddr_q, daddr_q, sport_q, dport_q};
  assign key_swp = {daddr_q, saddr_q, dport_q, sport_q};
  assign rd_key  = ram_rdata[WORD_W-1:32];
  assign rd_id   = ram_rdata[31:0];

  assign slot_x   = SX_W'(slot_q);
  assign slot_idx = slot_x[IDX_W-1:0];
  assign slot_ok  = ({1'b0, slot_x} < (SX_W + 1)'(MAX_ENTRIES)) && valid_q[slot_idx];

  // status to controller
  assign sts_o.mode      = mode_q;
  assign sts_o.last_addr = (rd_idx_q == IDX_W'(MAX_ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= ctt_mode_e'(mode_i);
      saddr_q <= src_addr_i;
      daddr_q <= dst_addr_i;
      sport_q <= src_port_i;
      dport_q <= dst_port_i;
      slot_q  <= slot_i;
    end
  end

  // key and id storage
  assign ram_re    = cmd_i.issue | cmd_i.rd_slot;
  assign ram_raddr = cmd_i.rd_slot ? slot_idx : rd_idx_q;
  assign ram_we    = cmd_i.commit && ins_ok;
  assign ram_wdata = {key_fwd, next_id_q};

  ctt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scan address and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      cmp_idx_q <= rd_idx_q;
      if (cmd_i.load) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
    end
  end

  // match trackers, lowest slot wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmd_i.load) begin
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      free_q  <= 1'b0;
    end else if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q] && rd_key == key_fwd && !hit_a_q) begin
        hit_a_q <= 1'b1;
      end
      if (valid_q[cmp_idx_q] && rd_key == key_swp && !hit_b_q) begin
        hit_b_q <= 1'b1;
      end
      if (!valid_q[cmp_idx_q] && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  // tracker payload
  always_ff @(posedge clk_i) begin
    if (cmp_vld_q) begin
      if (valid_q[cmp_idx_q] && rd_key == key_fwd && !hit_a_q) begin
        idx_a_q <= cmp_idx_q;
        id_a_q  <= rd_id;
      end
      if (valid_q[cmp_idx_q] && rd_key == key_swp && !hit_b_q) begin
        idx_b_q <= cmp_idx_q;
        id_b_q  <= rd_id;
      end
      if (!valid_q[cmp_idx_q] && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // operation outcome and table update
  assign side   = (sport_q > dport_q);
  assign ins_ok = (mode_q == MODE_INSERT) && (live_q != CNT_W'(MAX_ENTRIES))
                  && !hit_a_q && free_q;

  always_comb begin
    valid_d    = valid_q;
    live_d     = live_q;
    next_id_d  = next_id_q;
    res_status = STAT_OK;
    res_slot   = '0;
    res_id     = '0;
    res_client = 1'b0;
    pick_idx   = '0;
    pick_x     = '0;
    case (mode_q)
      MODE_INSERT: begin
        if (live_q == CNT_W'(MAX_ENTRIES)) begin
          res_status = STAT_FULL;
        end else if (hit_a_q) begin
          res_status = STAT_DUP;
          pick_idx   = idx_a_q;
          res_id     = id_a_q;
        end else if (free_q) begin
          pick_idx           = free_idx_q;
          res_id             = next_id_q;
          valid_d[free_idx_q] = 1'b1;
          live_d             = live_q + 1'b1;
          next_id_d          = next_id_q + 32'd1;
        end else begin
          res_status = STAT_FULL;
        end
      end
      MODE_FIND: begin
        // client owns the higher port first, then the other orientation
        if (side && hit_a_q) begin
          pick_idx   = idx_a_q;
          res_id     = id_a_q;
          res_client = 1'b1;
        end else if (hit_b_q) begin
          pick_idx = idx_b_q;
          res_id   = id_b_q;
        end else if (hit_a_q) begin
          pick_idx   = idx_a_q;
          res_id     = id_a_q;
          res_client = 1'b1;
        end else begin
          res_status = STAT_MISS;
        end
      end
      MODE_REMOVE: begin
        if (slot_ok) begin
          valid_d[slot_idx] = 1'b0;
          live_d            = live_q - 1'b1;
          res_id            = rd_id;
        end else begin
          res_status = STAT_MISS;
        end
      end
      MODE_CLEAR: begin
        valid_d = '0;
        live_d  = '0;
      end
      default: res_status = STAT_OK;
    endcase
    pick_x = SX_W'(pick_idx);
    if (mode_q == MODE_REMOVE) begin
      res_slot = slot_q;
    end else begin
      res_slot = pick_x[5:0];
    end
  end

  assign cnt_x = CX_W'(live_d);

  // table state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      live_q    <= '0;
      next_id_q <= 32'd1;
    end else if (cmd_i.commit) begin
      valid_q   <= valid_d;
      live_q    <= live_d;
      next_id_q <= next_id_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= res_status;
      slot_out_q <= res_slot;
      id_out_q   <= res_id;
      client_q   <= res_client;
      count_q    <= cnt_x[6:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_slot_o  = slot_out_q;
  assign conn_id_o     = id_out_q;
  assign client_side_o = client_q;
  assign entry_count_o = count_q;

endmodule

/* hw/rtl/connection_tuple_table_core.sv */
// connection tuple table: top level joining the sequencer and the datapath
// depends on ctt_pkg, ctt_ctrl, ctt_datapath (and ctt_ram below it)
//
// Bounded table of TCP connections keyed by source/destination address and
// port. Modes: insert (lowest free slot, running id from 1, duplicates
// rejected), find (both orientations, higher port as client tried first),
// remove one slot, clear all. One result beat per input beat, always with the
// live entry count. Insert and find scan the key memory one entry per cycle
// through its single read port; remove reads only the named slot and clear
// reads none. One operation is in flight at a time; a finished result waits in
// the output register while the next input beat is accepted.
module connection_tuple_table_core
  import ctt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [5:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [5:0]  entry_slot_o,
  output logic [31:0] conn_id_o,
  output logic        client_side_o,
  output logic [6:0]  entry_count_o
);

  ctt_cmd_t cmd;
  ctt_sts_t sts;

  // operation sequencer
  ctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage, compare and result datapath
  ctt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .src_addr_i    (src_addr_i),
    .dst_addr_i    (dst_addr_i),
    .src_port_i    (src_port_i),
    .dst_port_i    (dst_port_i),
    .slot_i        (slot_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_slot_o  (entry_slot_o),
    .conn_id_o     (conn_id_o),
    .client_side_o (client_side_o),
    .entry_count_o (entry_count_o)
  );

endmodule
